/* src/pjk_pkg.sv */
// Shared types and constants for the pointer joystick to keys block.
// Used by pjk_front, pjk_queue, pjk_back and pointer_joystick_to_keys.
`default_nettype none

package pjk_pkg;

   localparam int NUM_KEYS    = 7;
   localparam int NUM_BUTTONS = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef logic [NUM_KEYS-1:0] want_type;

   typedef enum logic [1:0] {
      OP_MOVE   = 2'd0,
      OP_BUTTON = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_CENTER_X       = 3'd0,
      REG_CENTER_Y       = 3'd1,
      REG_DEAD_ZONE      = 3'd2,
      REG_MAX_RADIUS     = 3'd3,
      REG_AXIS_THRESHOLD = 3'd4
   } reg_type;

   localparam int KEY_UP    = 0;
   localparam int KEY_DOWN  = 1;
   localparam int KEY_LEFT  = 2;
   localparam int KEY_RIGHT = 3;
   localparam int KEY_Z     = 4;

   localparam logic [15:0] CENTER_RESET    = 16'd0;
   localparam logic [11:0] DEAD_ZONE_RESET = 12'd30;
   localparam logic [11:0] MAX_RADIUS_RESET = 12'd200;
   localparam logic [8:0]  THRESHOLD_RESET = 9'd77;

   typedef enum logic [1:0] {
      FS_IDLE = 2'd0,
      FS_CALC = 2'd1,
      FS_PUSH = 2'd2
   } front_state_type;

   typedef enum logic [3:0] {
      ST_DX2   = 4'd0,
      ST_DY2   = 4'd1,
      ST_DZ2   = 4'd2,
      ST_MR2   = 4'd3,
      ST_THRMR = 4'd4,
      ST_THR2  = 4'd5,
      ST_PLO   = 4'd6,
      ST_PHI   = 4'd7,
      ST_SUM   = 4'd8,
      ST_CMP   = 4'd9
   } step_type;

   typedef struct packed {
      logic     valid;
      want_type want;
   } q_entry_type;

endpackage

`default_nettype wire

/* src/pjk_queue.sv */
// Short queue of key want vectors between front and back.
// Depends on pjk_pkg.
`default_nettype none

module pjk_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pjk_pkg::q_entry_type push,
   output logic                    full,
   input  wire logic               pop,
   output pjk_pkg::q_entry_type    head
);
   import pjk_pkg::*;

   want_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.want  = mem_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && head.valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.want;
      end
   end

endmodule

`default_nettype wire

/* src/pjk_front.sv */
// Front end: accepts items, keeps pointer, buttons and registers, and
// sequences the squared-distance compares of a tick. Depends on pjk_pkg.
`default_nettype none

module pjk_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [15:0] req_pointer_x,
   input  wire logic signed [15:0] req_pointer_y,
   input  wire logic [1:0]         req_button_index,
   input  wire logic               req_button_pressed,
   input  wire logic               req_active,
   input  wire logic               csr_valid,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data,
   output pjk_pkg::q_entry_type    push,
   input  wire logic               full
);
   import pjk_pkg::*;

   function automatic logic axis_hit(input logic [15:0] mag, input logic [31:0] mag2,
                                     input logic clamp, input logic [20:0] thrmr,
                                     input logic [51:0] tpd);
      logic lin;
      logic sq;
      lin = {1'b0, mag, 8'b0} > {4'b0, thrmr};
      sq  = {4'b0, mag2, 16'b0} > tpd;
      return (mag != '0) && (clamp ? sq : lin);
   endfunction

   front_state_type state_ff, state_in;
   step_type        step_ff, step_in;

   logic [15:0] center_x_ff, center_y_ff;
   logic [11:0] dead_zone_ff, max_radius_ff;
   logic [8:0]  threshold_ff;
   logic [15:0] pos_x_ff, pos_y_ff;
   logic [NUM_BUTTONS-1:0] button_held_ff;

   logic [15:0] adx_ff, ady_ff;
   logic        x_neg_ff, y_neg_ff;
   logic [31:0] dx2_ff, dy2_ff;
   logic [32:0] d2_ff;
   logic [23:0] dz2_ff, mr2_ff;
   logic [20:0] thrmr_ff;
   logic [17:0] thr2_ff;
   logic [34:0] plo_ff;
   logic [33:0] phi_ff;
   logic [51:0] tpd_ff;
   want_type    want_ff, want_in;

   logic        accept;
   op_type      op;
   logic [16:0] dx_w, dy_w, dx_abs, dy_abs;
   logic [11:0] mr_eff;
   logic [17:0] mul_a, mul_b;
   logic [35:0] mul_p;
   logic        outer, clamp, x_hit, y_hit;

   assign op     = op_type'(req_operation);
   assign accept = req_valid && req_ready;
   assign mr_eff = (max_radius_ff == '0) ? 12'd1 : max_radius_ff;

   assign dx_w   = {pos_x_ff[15], pos_x_ff} - {center_x_ff[15], center_x_ff};
   assign dy_w   = {pos_y_ff[15], pos_y_ff} - {center_y_ff[15], center_y_ff};
   assign dx_abs = dx_w[16] ? (17'd0 - dx_w) : dx_w;
   assign dy_abs = dy_w[16] ? (17'd0 - dy_w) : dy_w;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (req_valid && op == OP_TICK) begin
               state_in = req_active ? FS_CALC : FS_PUSH;
            end
         end
         FS_CALC: begin
            if (step_ff == ST_CMP) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == FS_IDLE);
      push.valid = (state_ff == FS_PUSH);
      push.want  = want_ff;
   end

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      step_in = step_ff;
      unique case (step_ff)
         ST_DX2: begin
            mul_a = {2'b0, adx_ff}; mul_b = {2'b0, adx_ff}; step_in = ST_DY2;
         end
         ST_DY2: begin
            mul_a = {2'b0, ady_ff}; mul_b = {2'b0, ady_ff}; step_in = ST_DZ2;
         end
         ST_DZ2: begin
            mul_a = {6'b0, dead_zone_ff}; mul_b = {6'b0, dead_zone_ff}; step_in = ST_MR2;
         end
         ST_MR2: begin
            mul_a = {6'b0, mr_eff}; mul_b = {6'b0, mr_eff}; step_in = ST_THRMR;
         end
         ST_THRMR: begin
            mul_a = {9'b0, threshold_ff}; mul_b = {6'b0, mr_eff}; step_in = ST_THR2;
         end
         ST_THR2: begin
            mul_a = {9'b0, threshold_ff}; mul_b = {9'b0, threshold_ff}; step_in = ST_PLO;
         end
         ST_PLO: begin
            mul_a = thr2_ff; mul_b = {1'b0, d2_ff[16:0]}; step_in = ST_PHI;
         end
         ST_PHI: begin
            mul_a = thr2_ff; mul_b = {2'b0, d2_ff[32:17]}; step_in = ST_SUM;
         end
         ST_SUM: step_in = ST_CMP;
         ST_CMP: step_in = ST_DX2;
         default: step_in = ST_DX2;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      outer = d2_ff >= {9'b0, dz2_ff};
      clamp = d2_ff > {9'b0, mr2_ff};
      x_hit = axis_hit(adx_ff, dx2_ff, clamp, thrmr_ff, tpd_ff);
      y_hit = axis_hit(ady_ff, dy2_ff, clamp, thrmr_ff, tpd_ff);
      want_in = '0;
      if (outer) begin
         want_in[KEY_UP]    = y_hit && y_neg_ff;
         want_in[KEY_DOWN]  = y_hit && !y_neg_ff;
         want_in[KEY_LEFT]  = x_hit && x_neg_ff;
         want_in[KEY_RIGHT] = x_hit && !x_neg_ff;
      end
      want_in[KEY_Z +: NUM_BUTTONS] = button_held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FS_IDLE;
         step_ff        <= ST_DX2;
         center_x_ff    <= CENTER_RESET;
         center_y_ff    <= CENTER_RESET;
         dead_zone_ff   <= DEAD_ZONE_RESET;
         max_radius_ff  <= MAX_RADIUS_RESET;
         threshold_ff   <= THRESHOLD_RESET;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         button_held_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == FS_CALC) begin
            step_ff <= step_in;
         end else begin
            step_ff <= ST_DX2;
         end
         if (csr_valid) begin
            unique case (reg_type'(csr_index))
               REG_CENTER_X:       center_x_ff   <= csr_data;
               REG_CENTER_Y:       center_y_ff   <= csr_data;
               REG_DEAD_ZONE:      dead_zone_ff  <= csr_data[11:0];
               REG_MAX_RADIUS:     max_radius_ff <= csr_data[11:0];
               REG_AXIS_THRESHOLD: threshold_ff  <= csr_data[8:0];
               default: ;
            endcase
         end
         if (accept && op == OP_MOVE) begin
            pos_x_ff <= req_pointer_x;
            pos_y_ff <= req_pointer_y;
         end
         if (accept && op == OP_BUTTON && req_button_index < 2'(NUM_BUTTONS)) begin
            button_held_ff[req_button_index] <= req_button_pressed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && op == OP_TICK) begin
         adx_ff   <= dx_abs[15:0];
         ady_ff   <= dy_abs[15:0];
         x_neg_ff <= dx_w[16];
         y_neg_ff <= dy_w[16];
         want_ff  <= '0;
      end
      if (state_ff == FS_CALC) begin
         case (step_ff)
            ST_DX2:   dx2_ff   <= mul_p[31:0];
            ST_DY2:   dy2_ff   <= mul_p[31:0];
            ST_DZ2: begin
               dz2_ff <= mul_p[23:0];
               d2_ff  <= {1'b0, dx2_ff} + {1'b0, dy2_ff};
            end
            ST_MR2:   mr2_ff   <= mul_p[23:0];
            ST_THRMR: thrmr_ff <= mul_p[20:0];
            ST_THR2:  thr2_ff  <= mul_p[17:0];
            ST_PLO:   plo_ff   <= mul_p[34:0];
            ST_PHI:   phi_ff   <= mul_p[33:0];
            ST_SUM:   tpd_ff   <= {17'b0, plo_ff} + {1'b0, phi_ff, 17'b0};
            ST_CMP:   want_ff  <= want_in;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

/* src/pjk_back.sv */
// Back end: pops want vectors, tracks pressed keys and emits key events
// through an output register. Depends on pjk_pkg.
`default_nettype none

module pjk_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pjk_pkg::q_entry_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [2:0]            rsp_key_index,
   output logic                  rsp_key_down,
   output logic                  rsp_last
);
   import pjk_pkg::*;

   want_type    key_pressed_ff;
   want_type    want_ff;
   want_type    diff_ff, diff_in;
   logic        valid_ff;
   logic [2:0]  key_ff;
   logic        down_ff;
   logic        last_ff;

   logic        emit;
   logic [2:0]  pick;
   want_type    pick_mask;
   logic        found;

   always_comb begin
      pick      = '0;
      pick_mask = '0;
      found     = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (!found && diff_ff[k]) begin
            found        = 1'b1;
            pick         = 3'(k);
            pick_mask[k] = 1'b1;
         end
      end
   end

   assign pop     = head.valid && (diff_ff == '0);
   assign emit    = (diff_ff != '0) && (!valid_ff || rsp_ready);
   assign diff_in = diff_ff & ~pick_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pressed_ff <= '0;
         diff_ff        <= '0;
         valid_ff       <= 1'b0;
      end else begin
         if (pop) begin
            key_pressed_ff <= head.want;
            diff_ff        <= head.want ^ key_pressed_ff;
         end else if (emit) begin
            diff_ff <= diff_in;
         end
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         want_ff <= head.want;
      end
      if (emit) begin
         key_ff  <= pick;
         down_ff <= |(want_ff & pick_mask);
         last_ff <= (diff_in == '0);
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_key_index = key_ff;
   assign rsp_key_down  = down_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

/* src/pointer_joystick_to_keys.sv */
// Pointer joystick to direction keys: top level joining front, queue and back.
// Depends on pjk_pkg, pjk_front, pjk_queue and pjk_back.
//
// Pointer moves and button changes can arrive every cycle while the front is
// idle. An active frame tick holds off new items while it latches the offset,
// runs ten steps through the one shared 18x18 multiplier, adder and compare
// sequence and hands the key want vector to the two-entry queue when it has
// room; an inactive tick skips the steps. The back pops a want vector when it
// has no events left and emits one key event per cycle while rsp_ready is
// high, via an output register, so events of one tick overlap the work of the
// next. Configuration writes are taken every cycle (csr_ready is high).
`default_nettype none

module pointer_joystick_to_keys (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [15:0] req_pointer_x,
   input  wire logic signed [15:0] req_pointer_y,
   input  wire logic [1:0]         req_button_index,
   input  wire logic               req_button_pressed,
   input  wire logic               req_active,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_key_index,
   output logic                    rsp_key_down,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   import pjk_pkg::*;

   q_entry_type push;
   q_entry_type head;
   logic        full;
   logic        pop;

   assign csr_ready = 1'b1;

   pjk_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pointer_x      (req_pointer_x),
      .req_pointer_y      (req_pointer_y),
      .req_button_index   (req_button_index),
      .req_button_pressed (req_button_pressed),
      .req_active         (req_active),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .push               (push),
      .full               (full)
   );

   pjk_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .pop   (pop),
      .head  (head)
   );

   pjk_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_index (rsp_key_index),
      .rsp_key_down  (rsp_key_down),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

/* dv/pjk_key_checker.sv */
// Checker for pointer_joystick_to_keys: watches the request, result and register channels,
// predicts the key events of each frame tick and compares them with the result transfers.
// Depends on pjk_pkg.
`timescale 1ns / 1ps

module pjk_key_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_pointer_x,
   input  logic signed [15:0] req_pointer_y,
   input  logic [1:0]         req_button_index,
   input  logic               req_button_pressed,
   input  logic               req_active,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_key_index,
   input  logic               rsp_key_down,
   input  logic               rsp_last,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 pending_events,
   output int                 fail_count
);
   import pjk_pkg::*;

   typedef struct packed {
      logic [2:0] key;
      logic       down;
      logic       last;
   } key_event_type;

   logic signed [15:0] ctr_x;
   logic signed [15:0] ctr_y;
   logic [11:0]        dead_radius;
   logic [11:0]        sat_radius;
   logic [8:0]         thr_frac;

   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [NUM_BUTTONS-1:0] buttons_held;
   want_type           keys_down;

   key_event_type expected_events[$];
   int fail_total = 0;

   function automatic bit deflects(input longint a, input longint d2, input bit clamped,
                                   input longint mr, input longint thr);
      if (a <= 0)
         return 1'b0;
      if (!clamped)
         return 256 * a > thr * mr;
      return 65536 * a * a > thr * thr * d2;
   endfunction

   function automatic want_type tick_wants(input logic act);
      longint dx, dy, d2, dz, mr, thr;
      bit clamped;
      want_type w;
      w = '0;
      if (act) begin
         dx = longint'(pos_x) - longint'(ctr_x);
         dy = longint'(pos_y) - longint'(ctr_y);
         d2 = dx * dx + dy * dy;
         dz = longint'(dead_radius);
         mr = (sat_radius == 12'd0) ? 1 : longint'(sat_radius);
         thr = longint'(thr_frac);
         if (d2 >= dz * dz) begin
            clamped = d2 > mr * mr;
            w[KEY_UP]    = deflects(-dy, d2, clamped, mr, thr);
            w[KEY_DOWN]  = deflects(dy, d2, clamped, mr, thr);
            w[KEY_LEFT]  = deflects(-dx, d2, clamped, mr, thr);
            w[KEY_RIGHT] = deflects(dx, d2, clamped, mr, thr);
         end
         w[KEY_Z +: NUM_BUTTONS] = buttons_held;
      end
      return w;
   endfunction

   task automatic report(input string field, input logic [2:0] exp_val,
                         input logic [2:0] act_val);
      fail_total++;
      $display("%0t pjk_key_checker: %s expected %0d actual %0d",
               $time, field, exp_val, act_val);
   endtask

   always @(posedge clock) begin
      key_event_type ev;
      want_type next_keys;
      want_type changed;
      int last_key;
      if (reset) begin
         ctr_x = CENTER_RESET;
         ctr_y = CENTER_RESET;
         dead_radius = DEAD_ZONE_RESET;
         sat_radius = MAX_RADIUS_RESET;
         thr_frac = THRESHOLD_RESET;
         pos_x = '0;
         pos_y = '0;
         buttons_held = '0;
         keys_down = '0;
         expected_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report("unexpected transfer, key_index", 3'bx, rsp_key_index);
            end else begin
               ev = expected_events.pop_front();
               if (rsp_key_index !== ev.key)
                  report("key_index", ev.key, rsp_key_index);
               if (rsp_key_down !== ev.down)
                  report("key_down", 3'(ev.down), 3'(rsp_key_down));
               if (rsp_last !== ev.last)
                  report("last", 3'(ev.last), 3'(rsp_last));
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CENTER_X:       ctr_x = csr_data;
               REG_CENTER_Y:       ctr_y = csr_data;
               REG_DEAD_ZONE:      dead_radius = csr_data[11:0];
               REG_MAX_RADIUS:     sat_radius = csr_data[11:0];
               REG_AXIS_THRESHOLD: thr_frac = csr_data[8:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            case (req_operation)
               OP_MOVE: begin
                  pos_x = req_pointer_x;
                  pos_y = req_pointer_y;
               end
               OP_BUTTON: begin
                  if (req_button_index < NUM_BUTTONS)
                     buttons_held[req_button_index] = req_button_pressed;
               end
               OP_TICK: begin
                  next_keys = tick_wants(req_active);
                  changed = next_keys ^ keys_down;
                  last_key = -1;
                  for (int k = 0; k < NUM_KEYS; k++)
                     if (changed[k])
                        last_key = k;
                  for (int k = 0; k < NUM_KEYS; k++) begin
                     if (changed[k]) begin
                        ev.key = 3'(k);
                        ev.down = next_keys[k];
                        ev.last = (k == last_key);
                        expected_events.insert(expected_events.size(), ev);
                     end
                  end
                  keys_down = next_keys;
               end
               default: ;
            endcase
         end
      end
      pending_events <= expected_events.size();
      fail_count <= fail_total;
   end

endmodule

/* dv/tb.sv */
// Testbench top for pointer_joystick_to_keys: clock, reset, register writes, directed and
// random request stimulus with bursts, result back-pressure, and the final verdict.
// Depends on pjk_pkg, pointer_joystick_to_keys and pjk_key_checker.
`timescale 1ns / 1ps

module tb;
   import pjk_pkg::*;

   localparam logic [1:0] OP_UNKNOWN     = 2'd3;
   localparam logic [1:0] BUTTON_UNKNOWN = 2'd3;
   localparam logic [2:0] REG_SPARE      = 3'd5;
   localparam int NUM_SPARE_REGS = 3;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_HOLD      = 400;
   localparam int PHASE_ITEMS    = 66;
   localparam int NUM_PHASES     = 6;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_operation;
   logic signed [15:0] req_pointer_x;
   logic signed [15:0] req_pointer_y;
   logic [1:0]         req_button_index;
   logic               req_button_pressed;
   logic               req_active;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [2:0]         rsp_key_index;
   logic               rsp_key_down;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;

   int pending;
   int fail_count;

   int burst_left = 0;
   int config_count = 0;
   int cur_span = 256;
   logic [15:0] cur_cx = '0;
   logic [15:0] cur_cy = '0;
   bit long_hold_req = 1'b0;

   always #5 clock = ~clock;

   pointer_joystick_to_keys i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pointer_x      (req_pointer_x),
      .req_pointer_y      (req_pointer_y),
      .req_button_index   (req_button_index),
      .req_button_pressed (req_button_pressed),
      .req_active         (req_active),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_index      (rsp_key_index),
      .rsp_key_down       (rsp_key_down),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   pjk_key_checker i_key_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pointer_x      (req_pointer_x),
      .req_pointer_y      (req_pointer_y),
      .req_button_index   (req_button_index),
      .req_button_pressed (req_button_pressed),
      .req_active         (req_active),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_index      (rsp_key_index),
      .rsp_key_down       (rsp_key_down),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .pending_events     (pending),
      .fail_count         (fail_count)
   );

   task automatic send_item(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                            input logic [1:0] bi, input logic bp, input logic act);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_pointer_x <= x;
      req_pointer_y <= y;
      req_button_index <= bi;
      req_button_pressed <= bp;
      req_active <= act;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic move_to(input logic [15:0] x, input logic [15:0] y);
      send_item(OP_MOVE, x, y, 2'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic set_button(input logic [1:0] bi, input logic bp);
      send_item(OP_BUTTON, 16'($urandom), 16'($urandom), bi, bp, 1'($urandom));
   endtask

   task automatic tick(input logic act);
      send_item(OP_TICK, 16'($urandom), 16'($urandom), 2'($urandom), 1'($urandom), act);
   endtask

   // drop valid, wait for every expected event, then let the front finish silent ticks
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [11:0] dz, input logic [11:0] mr,
                             input logic [8:0] thr);
      logic [15:0] word;
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      word = 16'($urandom);
      word[11:0] = dz;
      write_reg(REG_DEAD_ZONE, word);
      word = 16'($urandom);
      word[11:0] = mr;
      write_reg(REG_MAX_RADIUS, word);
      word = 16'($urandom);
      word[8:0] = thr;
      write_reg(REG_AXIS_THRESHOLD, word);
      write_reg(REG_SPARE + 3'(config_count % NUM_SPARE_REGS), 16'($urandom));
      csr_valid <= 1'b0;
      config_count++;
      cur_cx = cx;
      cur_cy = cy;
      cur_span = ((dz > mr) ? int'(dz) : int'(mr)) + 64;
   endtask

   task automatic random_item();
      int pick;
      logic [15:0] x, y;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
         x = 16'($urandom);
         y = 16'($urandom);
      end else begin
         x = cur_cx + 16'($urandom_range(0, 2 * cur_span) - cur_span);
         y = cur_cy + 16'($urandom_range(0, 2 * cur_span) - cur_span);
      end
      if (pick < 40)
         move_to(x, y);
      else if (pick < 60)
         set_button(2'($urandom_range(0, NUM_BUTTONS - 1)), 1'($urandom));
      else if (pick < 95)
         tick($urandom_range(0, 7) != 0);
      else if (pick < 98)
         set_button(BUTTON_UNKNOWN, 1'($urandom));
      else
         send_item(OP_UNKNOWN, x, y, 2'($urandom), 1'($urandom), 1'($urandom));
   endtask

   initial begin
      int rnd_cx, rnd_cy;
      req_valid = 1'b0;
      req_operation = OP_MOVE;
      req_pointer_x = '0;
      req_pointer_y = '0;
      req_button_index = '0;
      req_button_pressed = 1'b0;
      req_active = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero distance, each axis, both corners, dead zone, buttons
      tick(1'b1);
      move_to(16'sd100, 16'sd0);
      tick(1'b1);
      move_to(-16'sd32768, -16'sd32768);
      tick(1'b1);
      move_to(16'sd32767, 16'sd32767);
      tick(1'b1);
      move_to(16'sd10, 16'sd10);
      tick(1'b1);
      set_button(2'd0, 1'b1);
      set_button(2'd1, 1'b1);
      set_button(2'd2, 1'b1);
      set_button(BUTTON_UNKNOWN, 1'b1);
      send_item(OP_UNKNOWN, 16'($urandom), 16'($urandom), 2'($urandom), 1'b1, 1'b1);
      tick(1'b1);
      move_to(16'sd0, -16'sd150);
      tick(1'b1);
      tick(1'b0);
      set_button(2'd1, 1'b0);
      tick(1'b1);
      wait_idle();

      // extreme centre, no dead zone, zero radius, full threshold
      set_config(16'h8000, 16'h7FFF, 12'd0, 12'd0, 9'd256);
      move_to(-16'sd32768, 16'sd32767);
      tick(1'b1);
      move_to(-16'sd32767, 16'sd32767);
      tick(1'b1);
      wait_idle();

      // widest dead zone and radius, zero threshold
      set_config(16'h0000, 16'h0000, 12'd4095, 12'd4095, 9'd0);
      move_to(16'sd4094, 16'sd0);
      tick(1'b1);
      move_to(16'sd4095, 16'sd0);
      tick(1'b1);
      move_to(16'sd0, -16'sd4096);
      tick(1'b1);
      wait_idle();

      // threshold above one
      set_config(16'h0000, 16'h0000, 12'd0, 12'd200, 9'd511);
      tick(1'b1);
      wait_idle();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         rnd_cx = $urandom;
         rnd_cy = $urandom;
         case (phase)
            0: set_config(16'(rnd_cx), 16'(rnd_cy), 12'd0, 12'd4095, 9'd0);
            1: set_config(16'(rnd_cx), 16'(rnd_cy), 12'd4095, 12'd1, 9'd256);
            2: set_config(16'(rnd_cx), 16'(rnd_cy), 12'($urandom_range(0, 100)),
                          12'($urandom_range(1, 400)), 9'($urandom_range(257, 511)));
            default: set_config(16'(rnd_cx), 16'(rnd_cy), 12'($urandom_range(0, 150)),
                                12'($urandom_range(0, 600)), 9'($urandom_range(0, 300)));
         endcase
         if (phase == 3)
            long_hold_req = 1'b1;
         repeat (PHASE_ITEMS) random_item();
         wait_idle();
      end

      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      int stretch, mode;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stretch = $urandom_range(4, 48);
         mode = $urandom_range(0, 3);
         repeat (stretch) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 4) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
